// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/weo_pkg.sv =====
// Types, constants and helpers for the wheel encoder odometry unit
`timescale 1ns / 1ps

package weo_pkg;

   localparam int CountWidth  = 17;
   localparam int PrevWidth   = 16;
   localparam int PeriodWidth = 24;
   localparam int RptWidth    = 24;
   localparam int PosWidth    = 48;
   localparam int VelWidth    = 40;
   localparam int StepWidth   = 41;
   localparam int MagWidth    = 40;
   localparam int ScaleWidth  = 20;
   localparam int ProdWidth   = 60;
   localparam int QuotWidth   = 40;
   localparam int CsrIdxWidth = 2;
   localparam int BitCntWidth = $clog2(ScaleWidth);
   localparam int DivCntWidth = $clog2(QuotWidth);

   localparam logic [ScaleWidth-1:0]  US_PER_S    = 20'd1000000;
   localparam logic [RptWidth-1:0]    RPT_RESET   = 24'd25736;
   localparam logic [PeriodWidth-1:0] PERIOD_HOLD = 24'd1;
   localparam logic [VelWidth-1:0]    VEL_MAX     = {1'b0, {(VelWidth-1){1'b1}}};
   localparam logic [VelWidth-1:0]    VEL_MIN     = {1'b1, {(VelWidth-1){1'b0}}};

   localparam logic KIND_REPORT  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_INCREMENTAL = 2'd0,
      CSR_RPT_LEFT    = 2'd1,
      CSR_RPT_RIGHT   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_STEP,
      ST_SCALE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // signed velocity from magnitude quotient, clamped to 40 bits
   function automatic logic [VelWidth-1:0] sat_velocity(input logic neg, input logic ovf,
                                                        input logic [QuotWidth-1:0] q);
      logic big;
      big = ovf | q[QuotWidth-1];
      if (!neg) begin
         return big ? VEL_MAX : q;
      end
      return big ? VEL_MIN : VelWidth'(-q);
   endfunction

endpackage

// ===== src/wheel_encoder_odometry_unit.sv =====
// Wheel encoder odometry: positions and velocities of two wheels from encoder reports
//
// Usage:
//  - req_*: one encoder report word (kind, left/right count, period in us), taken at an
//    edge with req_valid high and req_stall low. Reports are handled one at a time.
//  - rsp_*: one result word per report (both positions and velocities), held in an output
//    register until taken (rsp_valid high, rsp_stall low). The next report is worked on
//    while a result waits; only the final load waits for the output register to free up.
//  - csr_*: register writes (index 0 mode, 1 left rad/tick, 2 right rad/tick), always
//    ready, to be written while no report is in flight. Other indexes are ignored.
// Steps from acceptance to rsp_valid for a report that updates velocity: a multiply, a
//  step add, bit-serial scaling by 1e6, a range check, restoring division one quotient
//  bit per cycle, and a load. A restart or the first absolute report goes straight to
//  the load; a report with period of 1 us or less goes from the step add to the load.
//  A new report is taken only once the previous one is loaded and the unit is idle.
// Reset (synchronous) clears positions, velocities, stored counts and restores the
//  register defaults. A stalled receiver holds the result and, once a second result is
//  ready, holds the unit in its final state with req_stall high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wheel_encoder_odometry_unit
   import weo_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic signed [CountWidth-1:0]  req_count_left,
   input  logic signed [CountWidth-1:0]  req_count_right,
   input  logic        [PeriodWidth-1:0] req_period_us,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [PosWidth-1:0]    rsp_position_left,
   output logic signed [PosWidth-1:0]    rsp_position_right,
   output logic signed [VelWidth-1:0]    rsp_velocity_left,
   output logic signed [VelWidth-1:0]    rsp_velocity_right,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic        [CsrIdxWidth-1:0] csr_index,
   input  logic        [RptWidth-1:0]    csr_wdata
);

   localparam logic [DivCntWidth-1:0] DIV_LAST  = DivCntWidth'(QuotWidth - 1);
   localparam logic [BitCntWidth-1:0] SCALE_TOP = BitCntWidth'(ScaleWidth - 1);

   state_type state_ff, state_in;

   logic                          incr_ff, incr_in;
   logic        [RptWidth-1:0]    rpt_ff [2];
   logic        [RptWidth-1:0]    rpt_in [2];
   logic                          have_prev_ff, have_prev_in;
   logic        [PrevWidth-1:0]   prev_ff [2];
   logic        [PrevWidth-1:0]   prev_in [2];
   logic signed [PosWidth-1:0]    pos_ff [2];
   logic signed [PosWidth-1:0]    pos_in [2];
   logic signed [VelWidth-1:0]    vel_ff [2];
   logic signed [VelWidth-1:0]    vel_in [2];
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [CountWidth-1:0]  delta_ff [2];
   logic signed [CountWidth-1:0]  delta_in [2];
   logic        [PeriodWidth-1:0] period_ff, period_in;
   logic                          vel_upd_ff, vel_upd_in;
   logic signed [StepWidth-1:0]   step_ff [2];
   logic signed [StepWidth-1:0]   step_in [2];
   logic                          neg_ff [2];
   logic                          neg_in [2];
   logic        [MagWidth-1:0]    mag_ff [2];
   logic        [MagWidth-1:0]    mag_in [2];
   logic        [ProdWidth-1:0]   acc_ff [2];
   logic        [ProdWidth-1:0]   acc_in [2];
   logic        [BitCntWidth-1:0] bit_cnt_ff, bit_cnt_in;
   logic                          ovf_ff [2];
   logic                          ovf_in [2];
   logic        [PeriodWidth-1:0] rem_ff [2];
   logic        [PeriodWidth-1:0] rem_in [2];
   logic        [QuotWidth-1:0]   dq_ff [2];
   logic        [QuotWidth-1:0]   dq_in [2];
   logic        [DivCntWidth-1:0] div_cnt_ff, div_cnt_in;
   logic signed [PosWidth-1:0]    rsp_pos_ff [2];
   logic signed [PosWidth-1:0]    rsp_pos_in [2];
   logic signed [VelWidth-1:0]    rsp_vel_ff [2];
   logic signed [VelWidth-1:0]    rsp_vel_in [2];

   logic accept;
   logic rsp_free;
   logic load_rsp;

   // ---------------------------------------------------------------- state machine
   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_RESTART) begin
                  state_in = ST_FINISH;
               end else if (incr_ff || have_prev_ff) begin
                  state_in = ST_MULT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MULT:   state_in = ST_STEP;
         ST_STEP:   state_in = vel_upd_ff ? ST_SCALE : ST_FINISH;
         ST_SCALE: begin
            if (bit_cnt_ff == '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin : fsm_outputs
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && (state_ff == ST_IDLE);
      rsp_free  = !rsp_valid_ff || !rsp_stall;
      load_rsp  = (state_ff == ST_FINISH) && rsp_free;
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin : datapath
      logic        [PrevWidth-1:0]   wrap     [2];
      logic        [PrevWidth-1:0]   now_cnt  [2];
      logic signed [CountWidth-1:0]  in_cnt   [2];
      logic signed [StepWidth:0]     prod     [2];
      logic        [ScaleWidth-1:0]  hi       [2];
      logic        [PeriodWidth:0]   trial    [2];
      logic                          fit      [2];
      logic        [VelWidth-1:0]    new_vel  [2];

      incr_in      = incr_ff;
      have_prev_in = have_prev_ff;
      period_in    = period_ff;
      vel_upd_in   = vel_upd_ff;
      bit_cnt_in   = bit_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      in_cnt[0]    = req_count_left;
      in_cnt[1]    = req_count_right;

      for (int w = 0; w < 2; w++) begin
         rpt_in[w]     = rpt_ff[w];
         prev_in[w]    = prev_ff[w];
         pos_in[w]     = pos_ff[w];
         vel_in[w]     = vel_ff[w];
         delta_in[w]   = delta_ff[w];
         step_in[w]    = step_ff[w];
         neg_in[w]     = neg_ff[w];
         mag_in[w]     = mag_ff[w];
         acc_in[w]     = acc_ff[w];
         ovf_in[w]     = ovf_ff[w];
         rem_in[w]     = rem_ff[w];
         dq_in[w]      = dq_ff[w];
         rsp_pos_in[w] = rsp_pos_ff[w];
         rsp_vel_in[w] = rsp_vel_ff[w];
         now_cnt[w]    = in_cnt[w][PrevWidth-1:0];
         wrap[w]       = now_cnt[w] - prev_ff[w];
         prod[w]       = delta_ff[w] * $signed({1'b0, rpt_ff[w]});
         hi[w]         = acc_ff[w][ProdWidth-1:QuotWidth];
         trial[w]      = {rem_ff[w], dq_ff[w][QuotWidth-1]};
         fit[w]        = trial[w] >= {1'b0, period_ff};
         new_vel[w]    = sat_velocity(neg_ff[w], ovf_ff[w], dq_ff[w]);
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_INCREMENTAL: incr_in   = csr_wdata[0];
            CSR_RPT_LEFT:    rpt_in[0] = csr_wdata;
            CSR_RPT_RIGHT:   rpt_in[1] = csr_wdata;
            default:         ;
         endcase
      end

      if (accept) begin
         period_in  = req_period_us;
         vel_upd_in = (req_kind == KIND_REPORT) && (incr_ff || have_prev_ff) &&
                      (req_period_us > PERIOD_HOLD);
         if (req_kind == KIND_RESTART) begin
            have_prev_in = 1'b0;
         end else if (incr_ff) begin
            for (int w = 0; w < 2; w++) begin
               delta_in[w] = in_cnt[w];
            end
         end else if (!have_prev_ff) begin
            // first absolute word only primes the counters
            have_prev_in = 1'b1;
            for (int w = 0; w < 2; w++) begin
               prev_in[w] = now_cnt[w];
               vel_in[w]  = '0;
            end
         end else begin
            for (int w = 0; w < 2; w++) begin
               delta_in[w] = {wrap[w][PrevWidth-1], wrap[w]};
               prev_in[w]  = now_cnt[w];
            end
         end
      end

      case (state_ff)
         ST_MULT: begin
            for (int w = 0; w < 2; w++) begin
               step_in[w] = prod[w][StepWidth-1:0];
            end
         end
         ST_STEP: begin
            bit_cnt_in = SCALE_TOP;
            for (int w = 0; w < 2; w++) begin
               pos_in[w] = pos_ff[w] + PosWidth'(step_ff[w]);
               neg_in[w] = step_ff[w][StepWidth-1];
               mag_in[w] = step_ff[w][StepWidth-1] ? MagWidth'(-step_ff[w])
                                                   : MagWidth'(step_ff[w]);
               acc_in[w] = '0;
            end
         end
         ST_SCALE: begin
            // Horner over the bits of 1e6, most significant first
            bit_cnt_in = bit_cnt_ff - 1'b1;
            for (int w = 0; w < 2; w++) begin
               acc_in[w] = {acc_ff[w][ProdWidth-2:0], 1'b0} +
                           (US_PER_S[bit_cnt_ff] ? ProdWidth'(mag_ff[w]) : '0);
            end
         end
         ST_CHECK: begin
            // top part already >= period means quotient needs more than 40 bits
            div_cnt_in = '0;
            for (int w = 0; w < 2; w++) begin
               ovf_in[w] = PeriodWidth'(hi[w]) >= period_ff;
               rem_in[w] = PeriodWidth'(hi[w]);
               dq_in[w]  = acc_ff[w][QuotWidth-1:0];
            end
         end
         ST_DIVIDE: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            for (int w = 0; w < 2; w++) begin
               rem_in[w] = fit[w] ? PeriodWidth'(trial[w] - {1'b0, period_ff})
                                  : trial[w][PeriodWidth-1:0];
               dq_in[w]  = {dq_ff[w][QuotWidth-2:0], fit[w]};
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               for (int w = 0; w < 2; w++) begin
                  rsp_pos_in[w] = pos_ff[w];
                  rsp_vel_in[w] = vel_upd_ff ? new_vel[w] : vel_ff[w];
                  if (vel_upd_ff) begin
                     vel_in[w] = new_vel[w];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         incr_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int w = 0; w < 2; w++) begin
            rpt_ff[w]  <= RPT_RESET;
            prev_ff[w] <= '0;
            pos_ff[w]  <= '0;
            vel_ff[w]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         incr_ff      <= incr_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int w = 0; w < 2; w++) begin
            rpt_ff[w]  <= rpt_in[w];
            prev_ff[w] <= prev_in[w];
            pos_ff[w]  <= pos_in[w];
            vel_ff[w]  <= vel_in[w];
         end
      end
   end

   always_ff @(posedge clock) begin
      period_ff  <= period_in;
      vel_upd_ff <= vel_upd_in;
      bit_cnt_ff <= bit_cnt_in;
      div_cnt_ff <= div_cnt_in;
      for (int w = 0; w < 2; w++) begin
         delta_ff[w]   <= delta_in[w];
         step_ff[w]    <= step_in[w];
         neg_ff[w]     <= neg_in[w];
         mag_ff[w]     <= mag_in[w];
         acc_ff[w]     <= acc_in[w];
         ovf_ff[w]     <= ovf_in[w];
         rem_ff[w]     <= rem_in[w];
         dq_ff[w]      <= dq_in[w];
         rsp_pos_ff[w] <= rsp_pos_in[w];
         rsp_vel_ff[w] <= rsp_vel_in[w];
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_left  = rsp_pos_ff[0];
   assign rsp_position_right = rsp_pos_ff[1];
   assign rsp_velocity_left  = rsp_vel_ff[0];
   assign rsp_velocity_right = rsp_vel_ff[1];

   // ---------------------------------------------------------------- assertions
   `ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff != ST_IDLE, "word accepted but unit stayed idle")
   `ASSERT_SAME(a_rem_below_period, clock, reset, (state_ff == ST_DIVIDE) && !ovf_ff[0], rem_ff[0] < period_ff, "divider remainder out of range")
   `ASSERT_NEXT(a_finish_holds, clock, reset, (state_ff == ST_FINISH) && rsp_valid_ff && rsp_stall, state_ff == ST_FINISH, "result overwritten while stalled")
   `ASSERT_NEXT(a_abs_primes, clock, reset, accept && (req_kind == KIND_REPORT) && !incr_ff, have_prev_ff, "absolute report did not record counts")

endmodule
